// ----- hw/rtl/ale_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the array linked list engine.
// No dependencies; top and finder use scoped names; the bench imports it.
package ale_pkg;

  // Fixed port widths
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 5;
  localparam int WORD_W   = 32;

  // Backward read emits at most this many beats
  localparam int MAX_OUT  = 16;
  localparam int RB_CNT_W = $clog2(MAX_OUT + 1);

  // Parameter defaults
  localparam int DEF_CAPACITY     = 16;
  localparam int DEF_RECORD_WIDTH = 32;

  // Free-slot finder group size
  localparam int FIND_GROUP = 16;
  localparam int FIND_IDX_W = $clog2(FIND_GROUP);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_FIRST = 3'd0,
    CMD_ADD_AFTER = 3'd1,
    CMD_ADD_LAST  = 3'd2,
    CMD_DEL_FIRST = 3'd3,
    CMD_DEL_AFTER = 3'd4,
    CMD_DEL_LAST  = 3'd5,
    CMD_CLEAR     = 3'd6,
    CMD_READ_BACK = 3'd7
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_FREE    = 3'd3,
    ST_NO_NEXT = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_INS_FRONT,
    S_INS_RD,
    S_INS_A,
    S_INS_B,
    S_DA_RD,
    S_DA_GET,
    S_DEL_RD,
    S_DEL_LINK,
    S_RB_RD,
    S_RB_EMIT,
    S_DONE
  } seq_state_t;

endpackage

// ----- hw/rtl/array_linked_list_engine_top.sv -----
`timescale 1ns / 1ps
// Top level of the array linked list engine: command sequencer and list state.
// Depends on ale_pkg, ale_ram (link and record tables) and ale_free_find.
//
// Usage:
//  - Input channel (in_valid/in_ready) takes one command beat: command,
//    position and the three record words for adds. in_ready is high only
//    while the sequencer is idle; one command is worked at a time.
//  - Result channel (out_valid/out_ready) gives one beat per command, or one
//    beat per element for read_backward (tail to head, last beat flagged by
//    out_final_result). A result sits in an output register, so the next
//    command can be taken while the previous result still waits.
//  - Every command first passes a check step; failed commands and clear_all
//    then go to the result step. Read backward follows its check step with
//    a table read and an emit step per element. Each link hop costs a read
//    step before use, since the link tables have one write port each and a
//    registered read.
//  - A stalled receiver holds the sequencer in its result step; nothing is
//    dropped and the next command waits.
//  - Reset (rst_n low, synchronous) empties the list: all slots free, head,
//    tail and count zero. Table contents are left as they are and are only
//    read at slots that are in use.
module array_linked_list_engine_top #(
  parameter int CAPACITY     = ale_pkg::DEF_CAPACITY,
  parameter int RECORD_WIDTH = ale_pkg::DEF_RECORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // command beats
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ale_pkg::CMD_W-1:0]     in_command,
  input  logic [ale_pkg::SLOT_W-1:0]    in_position,
  input  logic [ale_pkg::WORD_W-1:0]    in_code_value,
  input  logic [ale_pkg::WORD_W-1:0]    in_name_value,
  input  logic [ale_pkg::WORD_W-1:0]    in_title_value,
  // result beats
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ale_pkg::STATUS_W-1:0]  out_status,
  output logic [ale_pkg::SLOT_W-1:0]    out_slot,
  output logic [ale_pkg::COUNT_W-1:0]   out_count,
  output logic [ale_pkg::SLOT_W-1:0]    out_head_slot,
  output logic [ale_pkg::SLOT_W-1:0]    out_tail_slot,
  output logic [ale_pkg::WORD_W-1:0]    out_code,
  output logic [ale_pkg::WORD_W-1:0]    out_name,
  output logic [ale_pkg::WORD_W-1:0]    out_title,
  output logic                          out_final_result
);

  localparam int SW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int RW  = RECORD_WIDTH;
  localparam int KW  = ale_pkg::RB_CNT_W;
  localparam int OSW = ale_pkg::SLOT_W;
  localparam int OCW = ale_pkg::COUNT_W;
  localparam int OWW = ale_pkg::WORD_W;

  // ---------------------------------------------------------------- state
  ale_pkg::seq_state_t state_r, state_nxt;
  ale_pkg::cmd_t       cmd_r;
  ale_pkg::status_t    status_r, status_nxt;

  logic [OSW-1:0]      pos_r;
  logic [RW-1:0]       code_r, name_r, title_r;
  logic [SW-1:0]       s_r, s_nxt;        // slot being added / removed
  logic [SW-1:0]       p_r, p_nxt;        // predecessor slot
  logic [SW-1:0]       n_r, n_nxt;        // successor slot
  logic [SW-1:0]       cur_r, cur_nxt;    // backward read cursor
  logic [KW-1:0]       k_r, k_nxt;
  logic [KW-1:0]       limit_r, limit_nxt;
  logic [SW-1:0]       head_r, head_nxt;
  logic [SW-1:0]       tail_r, tail_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CAPACITY-1:0] in_use_r, in_use_nxt;

  // output register
  logic                out_valid_r;
  ale_pkg::status_t    out_status_r;
  logic [OSW-1:0]      out_slot_r, out_head_r, out_tail_r;
  logic [OCW-1:0]      out_count_r;
  logic [OWW-1:0]      out_code_r, out_name_r, out_title_r;
  logic                out_final_r;

  // ---------------------------------------------------------------- tables
  logic          nx_we, pv_we, rec_we;
  logic [SW-1:0] nx_waddr, nx_raddr, pv_waddr, pv_raddr, rec_raddr;
  logic [SW-1:0] nx_wdata, nx_rdata, pv_wdata, pv_rdata;
  logic [3*RW-1:0] rec_rdata;
  logic [SW-1:0] free_slot;

  ale_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_next_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .raddr (nx_raddr),
    .rdata (nx_rdata)
  );

  ale_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_prev_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (pv_waddr),
    .wdata (pv_wdata),
    .raddr (pv_raddr),
    .rdata (pv_rdata)
  );

  // record words packed code:name:title
  ale_ram #(.WIDTH(3 * RW), .DEPTH(CAPACITY)) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (s_r),
    .wdata ({code_r, name_r, title_r}),
    .raddr (rec_raddr),
    .rdata (rec_rdata)
  );

  ale_free_find #(.CAPACITY(CAPACITY)) u_free_find (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_use    (in_use_r),
    .free_slot (free_slot)
  );

  // ---------------------------------------------------------------- decode
  logic [SW-1:0] pos_idx;
  logic          pos_ok;
  logic          list_full, list_empty;
  logic          out_free;
  logic          rb_more;

  logic             load_out;
  ale_pkg::status_t o_status;
  logic [SW-1:0]    o_slot;
  logic [3*RW-1:0]  o_rec;
  logic             o_final;

  assign pos_idx    = SW'(pos_r);
  // named slot must exist and hold an element
  assign pos_ok     = (32'(pos_r) < CAPACITY) && in_use_r[pos_idx];
  assign list_full  = (count_r == CW'(CAPACITY));
  assign list_empty = (count_r == '0);
  assign out_free   = !out_valid_r || out_ready;
  // has_prev of an in-use slot is "not the head"
  assign rb_more    = (cur_r != head_r) && ((k_r + KW'(1)) < limit_r);

  assign in_ready = (state_r == ale_pkg::S_IDLE);

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    s_nxt      = s_r;
    p_nxt      = p_r;
    n_nxt      = n_r;
    cur_nxt    = cur_r;
    k_nxt      = k_r;
    limit_nxt  = limit_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    in_use_nxt = in_use_r;

    nx_we     = 1'b0;
    nx_waddr  = s_r;
    nx_wdata  = head_r;
    nx_raddr  = s_r;
    pv_we     = 1'b0;
    pv_waddr  = head_r;
    pv_wdata  = s_r;
    pv_raddr  = s_r;
    rec_we    = 1'b0;
    rec_raddr = cur_r;

    load_out = 1'b0;
    o_status = status_r;
    o_slot   = s_r;
    o_rec    = '0;
    o_final  = 1'b1;

    unique case (state_r)
      ale_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = ale_pkg::S_CHK;
        end
      end

      ale_pkg::S_CHK: begin
        status_nxt = ale_pkg::ST_OK;
        unique case (cmd_r) inside
          ale_pkg::CMD_ADD_FIRST, ale_pkg::CMD_ADD_AFTER, ale_pkg::CMD_ADD_LAST: begin
            if (list_full) begin
              status_nxt = ale_pkg::ST_FULL;
              s_nxt      = '0;
              state_nxt  = ale_pkg::S_DONE;
            end else if (cmd_r == ale_pkg::CMD_ADD_AFTER && !pos_ok) begin
              status_nxt = ale_pkg::ST_FREE;
              s_nxt      = '0;
              state_nxt  = ale_pkg::S_DONE;
            end else begin
              s_nxt = free_slot;
              // add_last on an empty list is an add at the front
              if (cmd_r == ale_pkg::CMD_ADD_FIRST ||
                  (cmd_r == ale_pkg::CMD_ADD_LAST && list_empty)) begin
                state_nxt = ale_pkg::S_INS_FRONT;
              end else begin
                p_nxt     = (cmd_r == ale_pkg::CMD_ADD_AFTER) ? pos_idx : tail_r;
                state_nxt = ale_pkg::S_INS_RD;
              end
            end
          end
          ale_pkg::CMD_DEL_FIRST, ale_pkg::CMD_DEL_LAST: begin
            if (list_empty) begin
              status_nxt = ale_pkg::ST_EMPTY;
              s_nxt      = '0;
              state_nxt  = ale_pkg::S_DONE;
            end else begin
              s_nxt     = (cmd_r == ale_pkg::CMD_DEL_FIRST) ? head_r : tail_r;
              state_nxt = ale_pkg::S_DEL_RD;
            end
          end
          ale_pkg::CMD_DEL_AFTER: begin
            if (!pos_ok) begin
              status_nxt = ale_pkg::ST_FREE;
              s_nxt      = '0;
              state_nxt  = ale_pkg::S_DONE;
            end else if (pos_idx == tail_r) begin
              status_nxt = ale_pkg::ST_NO_NEXT;
              s_nxt      = '0;
              state_nxt  = ale_pkg::S_DONE;
            end else begin
              p_nxt     = pos_idx;
              state_nxt = ale_pkg::S_DA_RD;
            end
          end
          ale_pkg::CMD_CLEAR: begin
            in_use_nxt = '0;
            count_nxt  = '0;
            head_nxt   = '0;
            tail_nxt   = '0;
            s_nxt      = '0;
            state_nxt  = ale_pkg::S_DONE;
          end
          ale_pkg::CMD_READ_BACK: begin
            if (list_empty) begin
              status_nxt = ale_pkg::ST_EMPTY;
              s_nxt      = '0;
              state_nxt  = ale_pkg::S_DONE;
            end else begin
              cur_nxt   = tail_r;
              k_nxt     = '0;
              limit_nxt = (32'(count_r) >= ale_pkg::MAX_OUT) ? KW'(ale_pkg::MAX_OUT)
                                                            : KW'(count_r);
              state_nxt = ale_pkg::S_RB_RD;
            end
          end
          default: begin
            state_nxt = ale_pkg::S_IDLE;
          end
        endcase
      end

      // new element at the front
      ale_pkg::S_INS_FRONT: begin
        rec_we = 1'b1;
        if (!list_empty) begin
          nx_we    = 1'b1;
          nx_waddr = s_r;
          nx_wdata = head_r;
          pv_we    = 1'b1;
          pv_waddr = head_r;
          pv_wdata = s_r;
        end else begin
          tail_nxt = s_r;
        end
        in_use_nxt[s_r] = 1'b1;
        head_nxt        = s_r;
        count_nxt       = count_r + CW'(1);
        state_nxt       = ale_pkg::S_DONE;
      end

      // new element after p: fetch next[p]
      ale_pkg::S_INS_RD: begin
        nx_raddr  = p_r;
        state_nxt = ale_pkg::S_INS_A;
      end

      ale_pkg::S_INS_A: begin
        n_nxt    = nx_rdata;
        nx_we    = 1'b1;
        nx_waddr = s_r;
        nx_wdata = nx_rdata;
        pv_we    = 1'b1;
        pv_waddr = s_r;
        pv_wdata = p_r;
        rec_we   = 1'b1;
        state_nxt = ale_pkg::S_INS_B;
      end

      // occupancy and count move together
      ale_pkg::S_INS_B: begin
        nx_we    = 1'b1;
        nx_waddr = p_r;
        nx_wdata = s_r;
        if (p_r != tail_r) begin
          pv_we    = 1'b1;
          pv_waddr = n_r;
          pv_wdata = s_r;
        end else begin
          tail_nxt = s_r;
        end
        in_use_nxt[s_r] = 1'b1;
        count_nxt       = count_r + CW'(1);
        state_nxt       = ale_pkg::S_DONE;
      end

      // delete after p: victim is next[p]
      ale_pkg::S_DA_RD: begin
        nx_raddr  = p_r;
        state_nxt = ale_pkg::S_DA_GET;
      end

      ale_pkg::S_DA_GET: begin
        s_nxt     = nx_rdata;
        state_nxt = ale_pkg::S_DEL_RD;
      end

      ale_pkg::S_DEL_RD: begin
        nx_raddr  = s_r;
        pv_raddr  = s_r;
        state_nxt = ale_pkg::S_DEL_LINK;
      end

      // unlink s: nx_rdata = next[s], pv_rdata = prev[s]
      ale_pkg::S_DEL_LINK: begin
        if (s_r != head_r) begin
          nx_we    = 1'b1;
          nx_waddr = pv_rdata;
          nx_wdata = nx_rdata;
        end else begin
          head_nxt = nx_rdata;
        end
        if (s_r != tail_r) begin
          pv_we    = 1'b1;
          pv_waddr = nx_rdata;
          pv_wdata = pv_rdata;
        end else begin
          tail_nxt = pv_rdata;
        end
        in_use_nxt[s_r] = 1'b0;
        count_nxt       = count_r - CW'(1);
        if (count_r == CW'(1)) begin
          head_nxt = '0;
          tail_nxt = '0;
        end
        state_nxt = ale_pkg::S_DONE;
      end

      ale_pkg::S_RB_RD: begin
        pv_raddr  = cur_r;
        rec_raddr = cur_r;
        state_nxt = ale_pkg::S_RB_EMIT;
      end

      // read address held so the registered data stays put during a stall
      ale_pkg::S_RB_EMIT: begin
        pv_raddr  = cur_r;
        rec_raddr = cur_r;
        if (out_free) begin
          load_out = 1'b1;
          o_status = ale_pkg::ST_OK;
          o_slot   = cur_r;
          o_rec    = rec_rdata;
          o_final  = !rb_more;
          if (rb_more) begin
            cur_nxt   = pv_rdata;
            k_nxt     = k_r + KW'(1);
            state_nxt = ale_pkg::S_RB_RD;
          end else begin
            state_nxt = ale_pkg::S_IDLE;
          end
        end
      end

      ale_pkg::S_DONE: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ale_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ale_pkg::S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ale_pkg::S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      in_use_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      in_use_r <= in_use_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    s_r      <= s_nxt;
    p_r      <= p_nxt;
    n_r      <= n_nxt;
    cur_r    <= cur_nxt;
    k_r      <= k_nxt;
    limit_r  <= limit_nxt;
    if (in_valid && in_ready) begin
      cmd_r   <= ale_pkg::cmd_t'(in_command);
      pos_r   <= in_position;
      code_r  <= RW'(in_code_value);
      name_r  <= RW'(in_name_value);
      title_r <= RW'(in_title_value);
    end
    if (load_out) begin
      out_status_r <= o_status;
      out_slot_r   <= OSW'(o_slot);
      out_count_r  <= OCW'(count_nxt);
      out_head_r   <= (count_nxt != '0) ? OSW'(head_nxt) : '0;
      out_tail_r   <= (count_nxt != '0) ? OSW'(tail_nxt) : '0;
      out_code_r   <= OWW'(o_rec[3*RW-1:2*RW]);
      out_name_r   <= OWW'(o_rec[2*RW-1:RW]);
      out_title_r  <= OWW'(o_rec[RW-1:0]);
      out_final_r  <= o_final;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_slot         = out_slot_r;
  assign out_count        = out_count_r;
  assign out_head_slot    = out_head_r;
  assign out_tail_slot    = out_tail_r;
  assign out_code         = out_code_r;
  assign out_name         = out_name_r;
  assign out_title        = out_title_r;
  assign out_final_result = out_final_r;

  // ---------------------------------------------------------------- checks
  // element count tracks the occupancy bits
  a_count_matches_use: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(in_use_r) == int'(count_r))
    else $error("element count differs from slots in use");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= CAPACITY)
    else $error("element count above capacity");

  // an accepted command leaves the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("command accepted back to back");

  // only a backward read leaves a non-final beat pending
  a_nonfinal_is_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_final_result) |-> (cmd_r == ale_pkg::CMD_READ_BACK && !in_ready))
    else $error("non-final result outside a backward read");

endmodule

// ----- hw/rtl/ale_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/ale_free_find.sv -----
`timescale 1ns / 1ps
// Lowest-free-slot finder: two-stage registered priority tree over in_use.
// Depends on ale_pkg. Result trails in_use through both register stages.
module ale_free_find #(
  parameter int CAPACITY = ale_pkg::DEF_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [CAPACITY-1:0]         in_use,
  output logic [$clog2(CAPACITY)-1:0] free_slot
);

  localparam int SW = $clog2(CAPACITY);
  localparam int G  = ale_pkg::FIND_GROUP;
  localparam int IW = ale_pkg::FIND_IDX_W;
  localparam int NG = (CAPACITY + G - 1) / G;

  logic [NG*G-1:0] used_pad;
  logic [NG-1:0]   grp_free_r, grp_free_nxt;
  logic [IW-1:0]   grp_idx_r [NG];
  logic [IW-1:0]   grp_idx_nxt [NG];
  logic [SW-1:0]   free_slot_r, free_slot_nxt;

  // slots past the end count as used
  for (genvar i = 0; i < NG * G; i++) begin : g_pad
    if (i < CAPACITY) begin : g_real
      assign used_pad[i] = in_use[i];
    end else begin : g_fill
      assign used_pad[i] = 1'b1;
    end
  end

  // stage 1: per-group find-first-zero
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_free_nxt[g] = ~&used_pad[g*G +: G];
      grp_idx_nxt[g]  = '0;
      for (int b = G - 1; b >= 0; b--) begin
        if (!used_pad[g*G + b]) begin
          grp_idx_nxt[g] = IW'(b);
        end
      end
    end
  end

  // stage 2: first group holding a free slot
  always_comb begin
    free_slot_nxt = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_free_r[g]) begin
        free_slot_nxt = SW'(g * G + int'(grp_idx_r[g]));
      end
    end
  end

  // reset value matches an all-free table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_free_r  <= '1;
      free_slot_r <= '0;
      for (int g = 0; g < NG; g++) begin
        grp_idx_r[g] <= '0;
      end
    end else begin
      grp_free_r  <= grp_free_nxt;
      free_slot_r <= free_slot_nxt;
      for (int g = 0; g < NG; g++) begin
        grp_idx_r[g] <= grp_idx_nxt[g];
      end
    end
  end

  assign free_slot = free_slot_r;

endmodule

// ----- tb/tb_array_linked_list_engine_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for array_linked_list_engine_top: directed corner commands, then random
// grow/shrink/mixed episodes checked against an in-bench list predictor. Needs ale_pkg and the RTL.
module tb_array_linked_list_engine_top;
  import ale_pkg::*;

  localparam int SLOTS = DEF_CAPACITY;

  // One result beat: as seen on the ports, or as predicted
  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  count;
    logic [SLOT_W-1:0]   head_slot;
    logic [SLOT_W-1:0]   tail_slot;
    logic [WORD_W-1:0]   code;
    logic [WORD_W-1:0]   name;
    logic [WORD_W-1:0]   title;
    logic                last;
  } list_beat_t;

  // Shadow copy of the slot table plus the queue of beats still owed by the block.
  class list_scoreboard;
    bit [SLOT_W-1:0]  fwd[SLOTS];
    bit [SLOT_W-1:0]  back[SLOTS];
    bit               fwd_ok[SLOTS];
    bit               back_ok[SLOTS];
    bit               used[SLOTS];
    bit [SLOT_W-1:0]  head;
    bit [SLOT_W-1:0]  tail;
    int unsigned      elems;
    bit [WORD_W-1:0]  code_mem[SLOTS];
    bit [WORD_W-1:0]  name_mem[SLOTS];
    bit [WORD_W-1:0]  title_mem[SLOTS];
    list_beat_t       owed_beats[$];
    int               errors;
    int               beats_seen;

    function new();
      wipe();
      errors = 0;
      beats_seen = 0;
    endfunction

    function void wipe();
      for (int i = 0; i < SLOTS; i++) begin
        fwd[i] = '0; back[i] = '0;
        fwd_ok[i] = 1'b0; back_ok[i] = 1'b0; used[i] = 1'b0;
        code_mem[i] = '0; name_mem[i] = '0; title_mem[i] = '0;
      end
      head = '0;
      tail = '0;
      elems = 0;
    endfunction

    function int pending();
      return owed_beats.size();
    endfunction

    // head/tail read as zero once the list is empty
    function void owe(status_t st, bit [SLOT_W-1:0] s, bit [WORD_W-1:0] c, bit [WORD_W-1:0] n,
                      bit [WORD_W-1:0] t, bit fin);
      list_beat_t b;
      b.status    = st;
      b.slot      = s;
      b.count     = elems[COUNT_W-1:0];
      b.head_slot = (elems != 0) ? head : '0;
      b.tail_slot = (elems != 0) ? tail : '0;
      b.code      = c;
      b.name      = n;
      b.title     = title_guard(t);
      b.last      = fin;
      owed_beats.push_back(b);
    endfunction

    function bit [WORD_W-1:0] title_guard(bit [WORD_W-1:0] t);
      return t;
    endfunction

    function bit [SLOT_W-1:0] lowest_free();
      for (int i = 0; i < SLOTS; i++)
        if (!used[i]) return i[SLOT_W-1:0];
      return '0;
    endfunction

    // Used by the stimulus to aim add_after / del_after at a live slot
    function bit [SLOT_W-1:0] some_live_slot();
      bit [SLOT_W-1:0] live[$];
      for (int i = 0; i < SLOTS; i++)
        if (used[i]) live.push_back(i[SLOT_W-1:0]);
      if (live.size() == 0) return SLOT_W'($urandom_range(0, SLOTS - 1));
      return live[$urandom_range(0, live.size() - 1)];
    endfunction

    // Link a new record in at the front, or after slot p
    function bit [SLOT_W-1:0] link_in(bit after, bit [SLOT_W-1:0] p, bit [WORD_W-1:0] c,
                                      bit [WORD_W-1:0] n, bit [WORD_W-1:0] t);
      bit [SLOT_W-1:0] s;
      s = lowest_free();
      code_mem[s]  = c;
      name_mem[s]  = n;
      title_mem[s] = t;
      used[s]      = 1'b1;
      if (!after) begin
        back_ok[s] = 1'b0;
        back[s]    = '0;
        if (elems != 0) begin
          fwd[s]        = head;
          fwd_ok[s]     = 1'b1;
          back[head]    = s;
          back_ok[head] = 1'b1;
        end else begin
          fwd[s]    = '0;
          fwd_ok[s] = 1'b0;
          tail      = s;
        end
        head = s;
      end else begin
        back[s]    = p;
        back_ok[s] = 1'b1;
        fwd_ok[s]  = fwd_ok[p];
        fwd[s]     = fwd[p];
        if (fwd_ok[p]) back[fwd[p]] = s;
        else tail = s;
        fwd[p]    = s;
        fwd_ok[p] = 1'b1;
      end
      elems++;
      return s;
    endfunction

    function void unlink(bit [SLOT_W-1:0] s);
      if (back_ok[s]) begin
        fwd_ok[back[s]] = fwd_ok[s];
        fwd[back[s]]    = fwd[s];
      end else begin
        head = fwd[s];
      end
      if (fwd_ok[s]) begin
        back_ok[fwd[s]] = back_ok[s];
        back[fwd[s]]    = back[s];
      end else begin
        tail = back[s];
      end
      used[s]    = 1'b0;
      fwd_ok[s]  = 1'b0;
      back_ok[s] = 1'b0;
      if (elems > 0) elems--;
      if (elems == 0) begin
        head = '0;
        tail = '0;
      end
    endfunction

    // Called on every accepted command beat: update the shadow list, queue the owed beats
    function void note_command(cmd_t op, bit [SLOT_W-1:0] pos, bit [WORD_W-1:0] c,
                               bit [WORD_W-1:0] n, bit [WORD_W-1:0] t);
      bit [SLOT_W-1:0] s;
      bit              full;
      bit              empty;
      bit              more;
      int unsigned     limit;
      int unsigned     k;
      full  = elems >= SLOTS;
      empty = elems == 0;
      case (op)
        CMD_ADD_FIRST, CMD_ADD_AFTER, CMD_ADD_LAST: begin
          // full wins over a bad position
          if (full) owe(ST_FULL, '0, '0, '0, '0, 1'b1);
          else if (op == CMD_ADD_AFTER && !used[pos]) owe(ST_FREE, '0, '0, '0, '0, 1'b1);
          else begin
            if (op == CMD_ADD_FIRST || (op == CMD_ADD_LAST && empty))
              s = link_in(1'b0, '0, c, n, t);
            else
              s = link_in(1'b1, (op == CMD_ADD_AFTER) ? pos : tail, c, n, t);
            owe(ST_OK, s, '0, '0, '0, 1'b1);
          end
        end
        CMD_DEL_FIRST, CMD_DEL_LAST: begin
          if (empty) owe(ST_EMPTY, '0, '0, '0, '0, 1'b1);
          else begin
            s = (op == CMD_DEL_FIRST) ? head : tail;
            unlink(s);
            owe(ST_OK, s, '0, '0, '0, 1'b1);
          end
        end
        CMD_DEL_AFTER: begin
          if (!used[pos]) owe(ST_FREE, '0, '0, '0, '0, 1'b1);
          else if (!fwd_ok[pos]) owe(ST_NO_NEXT, '0, '0, '0, '0, 1'b1);
          else begin
            s = fwd[pos];
            unlink(s);
            owe(ST_OK, s, '0, '0, '0, 1'b1);
          end
        end
        CMD_CLEAR: begin
          wipe();
          owe(ST_OK, '0, '0, '0, '0, 1'b1);
        end
        default: begin
          // read backward: tail to head, one beat per element
          if (empty) owe(ST_EMPTY, '0, '0, '0, '0, 1'b1);
          else begin
            limit = (elems < MAX_OUT) ? elems : MAX_OUT;
            s     = tail;
            k     = 0;
            more  = 1'b1;
            while (k < limit && more) begin
              more = back_ok[s] && (k + 1 < limit);
              owe(ST_OK, s, code_mem[s], name_mem[s], title_mem[s], !more);
              k++;
              s = back[s];
            end
          end
        end
      endcase
    endfunction

    // One line per mismatch
    task report(string msg);
      errors++;
      $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task cmp_field(string fname, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
      if (got !== want)
        report($sformatf("beat %0d %s: got %h, want %h", beats_seen, fname, got, want));
    endtask

    task check_result(list_beat_t got);
      list_beat_t want;
      if (owed_beats.size() == 0) begin
        report($sformatf("beat %0d arrived with nothing outstanding", beats_seen));
      end else begin
        want = owed_beats.pop_front();
        cmp_field("status", WORD_W'(got.status), WORD_W'(want.status));
        cmp_field("slot", WORD_W'(got.slot), WORD_W'(want.slot));
        cmp_field("count", WORD_W'(got.count), WORD_W'(want.count));
        cmp_field("head_slot", WORD_W'(got.head_slot), WORD_W'(want.head_slot));
        cmp_field("tail_slot", WORD_W'(got.tail_slot), WORD_W'(want.tail_slot));
        cmp_field("code", got.code, want.code);
        cmp_field("name", got.name, want.name);
        cmp_field("title", got.title, want.title);
        cmp_field("final_result", WORD_W'(got.last), WORD_W'(want.last));
      end
      beats_seen++;
    endtask
  endclass

  logic                clk;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    in_command     = '0;
  logic [SLOT_W-1:0]   in_position    = '0;
  logic [WORD_W-1:0]   in_code_value  = '0;
  logic [WORD_W-1:0]   in_name_value  = '0;
  logic [WORD_W-1:0]   in_title_value = '0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic [COUNT_W-1:0]  out_count;
  logic [SLOT_W-1:0]   out_head_slot;
  logic [SLOT_W-1:0]   out_tail_slot;
  logic [WORD_W-1:0]   out_code;
  logic [WORD_W-1:0]   out_name;
  logic [WORD_W-1:0]   out_title;
  logic                out_final_result;

  list_scoreboard sb = new();

  // calm: no idling on either side for the current stretch
  bit calm       = 1'b0;
  int stall_left = 0;

  array_linked_list_engine_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_position      (in_position),
    .in_code_value    (in_code_value),
    .in_name_value    (in_name_value),
    .in_title_value   (in_title_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_slot         (out_slot),
    .out_count        (out_count),
    .out_head_slot    (out_head_slot),
    .out_tail_slot    (out_tail_slot),
    .out_code         (out_code),
    .out_name         (out_name),
    .out_title        (out_title),
    .out_final_result (out_final_result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run of ~330 commands
  initial begin
    #2_000_000;
    $display("array_linked_list_engine_top regression: fail");
    $finish;
  end

  // Receiver: random stall bursts, none while calm
  always @(posedge clk) begin
    if (calm) begin
      stall_left = 0;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: both channels sampled on the same edge the handshake completes.
  // Command beats are noted before results are checked; a result never comes
  // on the edge its own command is taken, so the order is only for tidiness.
  always @(posedge clk) begin : monitor
    list_beat_t seen;
    if (rst_n && in_valid && in_ready)
      sb.note_command(cmd_t'(in_command), in_position, in_code_value, in_name_value,
                      in_title_value);
    if (rst_n && out_valid && out_ready) begin
      seen.status    = out_status;
      seen.slot      = out_slot;
      seen.count     = out_count;
      seen.head_slot = out_head_slot;
      seen.tail_slot = out_tail_slot;
      seen.code      = out_code;
      seen.name      = out_name;
      seen.title     = out_title;
      seen.last      = out_final_result;
      sb.check_result(seen);
    end
  end

  // One command beat. Valid stays up across back-to-back beats (single NBA per step);
  // a random gap drops it first unless calm.
  task automatic send(cmd_t op, bit [SLOT_W-1:0] pos, bit [WORD_W-1:0] c, bit [WORD_W-1:0] n,
                      bit [WORD_W-1:0] t);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= op;
    in_position    <= pos;
    in_code_value  <= c;
    in_name_value  <= n;
    in_title_value <= t;
    do @(posedge clk); while (!in_ready);
  endtask

  // Sender holds off until every owed beat is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Record word: extremes now and then, otherwise fully random
  function automatic bit [WORD_W-1:0] rand_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // grow_pct steers the add/delete mix so episodes reach full and empty
  task automatic random_item(int grow_pct);
    int              r;
    cmd_t            op;
    bit [SLOT_W-1:0] pos;
    r = $urandom_range(0, 99);
    if (r < 8) op = CMD_READ_BACK;
    else if (r < 10 && grow_pct < 70) op = CMD_CLEAR;
    else if ($urandom_range(0, 99) < grow_pct) op = cmd_t'($urandom_range(0, 2));
    else op = cmd_t'($urandom_range(3, 5));
    // mostly a live slot, sometimes any slot (free-slot noise)
    if ($urandom_range(0, 9) == 0) pos = SLOT_W'($urandom_range(0, SLOTS - 1));
    else pos = sb.some_live_slot();
    send(op, pos, rand_word(), rand_word(), rand_word());
  endtask

  task automatic episode(int grow_pct, int items);
    repeat (items) random_item(grow_pct);
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-list statuses, free slot, then a small list built slot by slot
    send(CMD_READ_BACK, 4'd0, '0, '0, '0);                  // empty
    send(CMD_DEL_FIRST, 4'd0, '0, '0, '0);                  // empty
    send(CMD_DEL_LAST, 4'd0, '0, '0, '0);                   // empty
    send(CMD_DEL_AFTER, 4'd15, '0, '0, '0);                 // slot free
    send(CMD_ADD_AFTER, 4'd0, '1, '1, '1);                  // slot free
    send(CMD_CLEAR, 4'd0, '0, '0, '0);                      // clear when already empty
    send(CMD_ADD_LAST, 4'd0, '1, '1, '1);                   // add_last on empty -> front
    send(CMD_ADD_FIRST, 4'd0, '0, '0, '0);                  // list 1,0
    send(CMD_ADD_AFTER, 4'd1, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 32'h0F0F_F0F0); // 1,2,0
    send(CMD_ADD_LAST, 4'd0, 32'h8000_0001, 32'h7FFF_FFFE, $urandom);      // 1,2,0,3
    send(CMD_ADD_AFTER, 4'd3, $urandom, $urandom, $urandom);                // after tail
    send(CMD_DEL_AFTER, 4'd4, '0, '0, '0);                  // nothing after tail
    send(CMD_DEL_AFTER, 4'd2, '0, '0, '0);                  // drops slot 0
    send(CMD_ADD_FIRST, 4'd0, $urandom, $urandom, $urandom); // reuses lowest free slot
    send(CMD_READ_BACK, 4'd0, '0, '0, '0);
    send(CMD_DEL_FIRST, 4'd0, '0, '0, '0);
    send(CMD_DEL_LAST, 4'd0, '0, '0, '0);
    send(CMD_ADD_AFTER, 4'd15, '0, '0, '0);                 // slot free
    send(CMD_DEL_AFTER, 4'd0, '0, '0, '0);                  // slot just freed
    send(CMD_READ_BACK, 4'd0, '0, '0, '0);
    send(CMD_CLEAR, 4'd0, '0, '0, '0);
    send(CMD_READ_BACK, 4'd0, '0, '0, '0);                  // empty after clear
    drain();

    // Random episodes; each ends with the sender held off until all beats are back.
    // Grow phases run into full (16-beat reads, full status); shrink runs to empty.
    episode(80, 60);
    calm = 1'b1;
    episode(50, 50);
    calm = 1'b0;
    episode(20, 60);
    episode(85, 50);
    episode(50, 40);
    calm = 1'b1;
    episode(50, 40);

    // Settle: longest command is a 16-element read
    repeat (50) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d result beats never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("array_linked_list_engine_top regression: pass");
    end else begin
      $display("array_linked_list_engine_top regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/ale_pkg.sv
hw/rtl/ale_ram.sv
hw/rtl/ale_free_find.sv
hw/rtl/array_linked_list_engine_top.sv
tb/tb_array_linked_list_engine_top.sv
